// File: src/assert_macros.svh
// Assertion macros used by rolling_sum_chunk_splitter.sv.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge once reset is released.
`define RSCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that post holds in the cycle after pre, once reset is released.
`define RSCS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: src/rscs_pkg.sv
`timescale 1ns / 1ps
// Types, constants and helpers for the rolling-sum chunk splitter.
// No dependencies.
package rscs_pkg;

  localparam int SUM_W   = 32;
  localparam int CNT_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int MBITS_W = 5;

  localparam logic [MBITS_W-1:0] MASK_BITS_RESET = 5'd13;
  localparam logic [CNT_W-1:0]   CNT_MAX         = {CNT_W{1'b1}};

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             boundary;
  } upd_t;

  function automatic logic [SUM_W-1:0] split_mask(input logic [MBITS_W-1:0] nbits);
    logic [SUM_W-1:0] one;
    one = {{(SUM_W-1){1'b0}}, 1'b1};
    return (one << nbits) - one;
  endfunction

endpackage

// File: src/rscs_window_ram.sv
`timescale 1ns / 1ps
// Byte window memory: one write port, one read port, registered read data.
// Depends on rscs_pkg for the byte width.
module rscs_window_ram
  import rscs_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/rscs_update.sv
`timescale 1ns / 1ps
// Rolling-sum step: rotate-xor update, boundary test and saturating count.
// Depends on rscs_pkg for widths, the mask helper and the result struct.
module rscs_update
  import rscs_pkg::*;
(
  input  logic [SUM_W-1:0]   sum_in,
  input  logic [CNT_W-1:0]   count_in,
  input  logic [BYTE_W-1:0]  leave_byte,
  input  logic [BYTE_W-1:0]  new_byte,
  input  logic [MBITS_W-1:0] mask_bits,
  output upd_t               upd
);

  logic [SUM_W-1:0] rot;
  logic [SUM_W-1:0] sum_nxt;

  assign rot     = {sum_in[SUM_W-2:0], sum_in[SUM_W-1]};
  assign sum_nxt = rot ^ {{(SUM_W-BYTE_W){1'b0}}, leave_byte}
                       ^ {{(SUM_W-BYTE_W){1'b0}}, new_byte};

  always_comb begin
    upd.sum      = sum_nxt;
    upd.count    = (count_in == CNT_MAX) ? CNT_MAX : count_in + {{(CNT_W-1){1'b0}}, 1'b1};
    upd.boundary = ((sum_nxt & split_mask(mask_bits)) == '0);
  end

endmodule

// File: src/rolling_sum_chunk_splitter.sv
`timescale 1ns / 1ps
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | in_data_byte
// out_    | output    | out_valid/out_stall| out_byte_out, out_boundary, out_chunk_length,
//         |           |                    | out_rolling_sum_out
// cfg_    | input     | cfg_valid/cfg_ready| cfg_split_mask_bits
// One byte per cycle unless out_stall holds; bytes pass the s1 and output registers.
// The window RAM read is issued at accept on the predicted next index; the
// rotate-xor, mask test and write-back happen as the item moves to the output.
// Reset (synchronous) clears sum, count, index and the wrap flag; the window RAM
// needs no clearing pass, entries count as zero until the index has wrapped.
// A stalled output holds its register; the input stalls only while both stages are full.
// Depends on rscs_pkg, rscs_update, rscs_window_ram and assert_macros.svh.
`include "assert_macros.svh"

module rolling_sum_chunk_splitter
  import rscs_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte_out,
  output logic               out_boundary,
  output logic [31:0]        out_chunk_length,
  output logic [31:0]        out_rolling_sum_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_split_mask_bits
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  logic               s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic               out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_boundary_r;
  logic [CNT_W-1:0]   out_len_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               wrapped_r, wrapped_nxt;
  logic [MBITS_W-1:0] mask_bits_r;

  logic               accept;
  logic               s1_move;
  logic               commit;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   rd_addr;
  logic [BYTE_W-1:0]  rd_data;
  logic [BYTE_W-1:0]  leave_byte;
  upd_t               upd;

  assign s1_move  = !out_valid_r || !out_stall;
  assign commit   = s1_valid_r && s1_move;
  assign in_stall = s1_valid_r && !s1_move;
  assign accept   = in_valid && !in_stall;
  assign cfg_ready = !s1_valid_r;

  assign idx_inc    = (idx_r == IDX_LAST) ? '0 : idx_r + IDX_ONE;
  // predict no boundary for the item ahead; a boundary forces the leaving byte to zero
  assign rd_addr    = s1_valid_r ? idx_inc : idx_r;
  assign leave_byte = wrapped_r ? rd_data : '0;

  rscs_window_ram #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (commit),
    .waddr (idx_r),
    .wdata (s1_byte_r),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rscs_update u_update (
    .sum_in     (sum_r),
    .count_in   (count_r),
    .leave_byte (leave_byte),
    .new_byte   (s1_byte_r),
    .mask_bits  (mask_bits_r),
    .upd        (upd)
  );

  always_comb begin
    s1_valid_nxt  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
    out_valid_nxt = commit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    wrapped_nxt   = wrapped_r;
    if (commit) begin
      sum_nxt = upd.sum;
      if (upd.boundary) begin
        count_nxt   = '0;
        idx_nxt     = '0;
        wrapped_nxt = 1'b0;
      end else begin
        count_nxt   = upd.count;
        idx_nxt     = idx_inc;
        wrapped_nxt = wrapped_r || (idx_r == IDX_LAST);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      wrapped_r   <= 1'b0;
      mask_bits_r <= MASK_BITS_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      wrapped_r   <= wrapped_nxt;
      if (cfg_valid && cfg_ready) begin
        mask_bits_r <= cfg_split_mask_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_data_byte;
    end
    if (commit) begin
      out_byte_r     <= s1_byte_r;
      out_boundary_r <= upd.boundary;
      out_len_r      <= upd.count;
      out_sum_r      <= upd.sum;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte_out        = out_byte_r;
  assign out_boundary        = out_boundary_r;
  assign out_chunk_length    = out_len_r;
  assign out_rolling_sum_out = out_sum_r;

  `RSCS_ASSERT(a_len_nonzero, out_valid_r |-> (out_len_r != '0), "chunk length of zero")
  `RSCS_ASSERT(a_stall_full, in_stall |-> (s1_valid_r && out_valid_r), "stall without full pipe")
  `RSCS_ASSERT(a_idx_range, idx_r <= IDX_LAST, "window index out of range")
  `RSCS_ASSERT_NEXT(a_split_clear, commit && upd.boundary,
                    (idx_r == '0) && !wrapped_r && (count_r == '0),
                    "boundary did not clear window state")

endmodule

// File: sim/tb_rolling_sum_chunk_splitter.sv
`timescale 1ns / 1ps
// Self-checking testbench for rolling_sum_chunk_splitter: random byte streams, mask settings
// and handshake idling, every result checked against a behavioral rolling-sum predictor.
// Depends on rscs_pkg and the RTL of the block.
module tb_rolling_sum_chunk_splitter;
  import rscs_pkg::*;

  localparam int WINDOW_DEPTH = 64;
  localparam int PHASE_ITEMS  = 54;
  localparam int NUM_PHASES   = 9;

  typedef enum int {PAT_RANDOM, PAT_RUN, PAT_PAIR, PAT_REPEAT} byte_pattern_t;

  typedef struct {
    logic [BYTE_W-1:0] byte_out;
    logic              boundary;
    logic [CNT_W-1:0]  chunk_length;
    logic [SUM_W-1:0]  rolling_sum;
  } chunk_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_data_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BYTE_W-1:0]  out_byte_out;
  logic               out_boundary;
  logic [CNT_W-1:0]   out_chunk_length;
  logic [SUM_W-1:0]   out_rolling_sum_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [MBITS_W-1:0] cfg_split_mask_bits = '0;

  logic [BYTE_W-1:0]  win_bytes [WINDOW_DEPTH];
  logic [5:0]         win_pos = '0;
  logic [SUM_W-1:0]   sum_state = '0;
  logic [CNT_W-1:0]   count_state = '0;
  logic [MBITS_W-1:0] split_bits = MASK_BITS_RESET;

  logic [BYTE_W-1:0]  byte_q [$];
  chunk_result_t      chunk_results_q [$];
  int                 gap_left = 0;
  int                 stall_left = 0;
  int                 in_idle_pct = 0;
  int                 out_idle_pct = 0;
  int                 errors = 0;

  rolling_sum_chunk_splitter #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte_out        (out_byte_out),
    .out_boundary        (out_boundary),
    .out_chunk_length    (out_chunk_length),
    .out_rolling_sum_out (out_rolling_sum_out),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_split_mask_bits (cfg_split_mask_bits)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic chunk_result_t roll_byte(input logic [BYTE_W-1:0] b);
    chunk_result_t    r;
    logic [SUM_W-1:0] low_mask;
    low_mask = ~({SUM_W{1'b1}} << split_bits);
    sum_state = {sum_state[SUM_W-2:0], sum_state[SUM_W-1]} ^ SUM_W'(win_bytes[win_pos]) ^
                SUM_W'(b);
    win_bytes[win_pos] = b;
    win_pos = win_pos + 6'd1;
    if (count_state != CNT_MAX) count_state = count_state + 1'b1;
    r.byte_out = b;
    r.chunk_length = count_state;
    r.rolling_sum = sum_state;
    r.boundary = (sum_state & low_mask) == '0;
    if (r.boundary) begin
      count_state = '0;
      win_pos = '0;
      foreach (win_bytes[i]) win_bytes[i] = '0;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : drive
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) chunk_results_q.push_back(roll_byte(in_data_byte));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (byte_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < in_idle_pct) begin
          gap_left <= $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data_byte <= byte_q.pop_front();
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    chunk_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (chunk_results_q.size() == 0) begin
          $display("%0t: unexpected transaction, byte %h", $time, out_byte_out);
          errors++;
        end else begin
          want = chunk_results_q.pop_front();
          check_field("byte_out", 32'(want.byte_out), 32'(out_byte_out));
          check_field("boundary", 32'(want.boundary), 32'(out_boundary));
          check_field("chunk_length", want.chunk_length, out_chunk_length);
          check_field("rolling_sum_out", want.rolling_sum, out_rolling_sum_out);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        stall_left <= $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_split_bits(input logic [MBITS_W-1:0] v);
    cfg_split_mask_bits <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    split_bits = v;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (byte_q.size() != 0 || in_valid || chunk_results_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_segment(input byte_pattern_t pat, input int len);
    logic [BYTE_W-1:0] block [WINDOW_DEPTH];
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    a = $urandom_range(0, 255);
    b = $urandom_range(0, 255);
    foreach (block[i]) block[i] = $urandom_range(0, 255);
    for (int k = 0; k < len; k++) begin
      case (pat)
        PAT_RUN:    byte_q.push_back(a);
        PAT_PAIR:   byte_q.push_back($urandom_range(0, 1) ? a : b);
        PAT_REPEAT: byte_q.push_back(block[k % WINDOW_DEPTH]);
        default:    byte_q.push_back($urandom_range(0, 255));
      endcase
    end
  endtask

  initial begin : stimulus
    logic [MBITS_W-1:0] phase_bits [NUM_PHASES];
    int                 left;
    int                 len;
    int                 pick;
    byte_pattern_t      pat;
    phase_bits = '{5'd4, 5'd8, 5'd2, 5'd13, 5'd0, 5'd6, 5'd31, 5'd10, 5'd5};
    foreach (win_bytes[i]) win_bytes[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    in_idle_pct = 20;
    out_idle_pct = 20;
    byte_q = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'hFE};
    wait_drained();
    write_split_bits(5'd0);
    byte_q = '{8'hFF, 8'h00, 8'h3C, 8'hC3};
    wait_drained();
    write_split_bits(5'd1);
    byte_q = '{8'h01, 8'h03, 8'h02, 8'hFF, 8'h00};
    wait_drained();
    write_split_bits(5'd31);
    byte_q = '{8'hFF, 8'hFF, 8'h00, 8'h80, 8'h01};
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_split_bits(phase_bits[p]);
      in_idle_pct = (p == NUM_PHASES - 1) ? 0 : (p % 3) * 20;
      out_idle_pct = (p == NUM_PHASES - 1) ? 0 : ((p + 1) % 3) * 20;
      left = PHASE_ITEMS;
      while (left > 0) begin
        pick = $urandom_range(0, 9);
        pat = pick < 5 ? PAT_RANDOM : pick < 7 ? PAT_RUN : pick < 9 ? PAT_PAIR : PAT_REPEAT;
        len = $urandom_range(4, pat == PAT_REPEAT ? 140 : 70);
        if (len > left) len = left;
        queue_segment(pat, len);
        left -= len;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("rolling_sum_chunk_splitter regression: pass");
    end else begin
      $display("rolling_sum_chunk_splitter regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("rolling_sum_chunk_splitter regression: fail");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/rscs_pkg.sv
src/rscs_window_ram.sv
src/rscs_update.sv
src/rolling_sum_chunk_splitter.sv
sim/tb_rolling_sum_chunk_splitter.sv
